// ===== hw/rtl/ssdf_pkg.sv =====
// Shared types, constants and the multiplexer table of the sensor scan debounce filter.
package ssdf_pkg;

    // Field widths fixed by the transaction formats.
    localparam int SAMPLE_BITS  = 10;
    localparam int SWITCH_W     = 8;
    localparam int SLOT_W       = 6;
    localparam int NEXT_W       = 5;
    localparam int MUX_W        = 4;
    localparam int COUNT_W      = 8;
    localparam int DEB_W        = 2;
    localparam int SHIFT_W      = 3;
    localparam int MAX_SHIFT    = 7;
    localparam int ACC_W        = SAMPLE_BITS + MAX_SHIFT + 1;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 8;

    // Scan sequencing constants.
    localparam logic [COUNT_W-1:0] STARTUP_RESET  = 8'd100;
    localparam logic [COUNT_W-1:0] SCAN_THRESHOLD = 8'd25;
    localparam logic [SLOT_W-1:0]  SCAN_START     = 6'h20;
    localparam logic [SLOT_W-1:0]  LAST_SLOT      = 6'd16;
    localparam logic [SLOT_W-1:0]  BANK_SLOTS     = 6'd16;
    localparam logic [SLOT_W-1:0]  HIGH_BANK_SLOT = 6'd8;

    // Configuration register indexes and reset values.
    localparam logic [CFG_INDEX_W-1:0] REG_STARTUP_DELAY  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_SHIFT   = 2'd2;
    localparam logic [DEB_W-1:0]       DEBOUNCE_RESET     = 2'd3;
    localparam logic [SHIFT_W-1:0]     SHIFT_RESET        = 3'd6;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] adc_sample;
        logic                   switch_level;
    } ssdf_in_t;

    typedef struct packed {
        logic                   scan_active;
        logic [SWITCH_W-1:0]    switch_states;
        logic [SLOT_W-1:0]      done_slot;
        logic                   filtered_valid;
        logic [SAMPLE_BITS-1:0] filtered_value;
        logic [NEXT_W-1:0]      next_slot;
        logic                   high_current_select;
        logic [MUX_W-1:0]       mux_code;
        logic                   calibrate;
    } ssdf_out_t;

    // Classified work for the back part.
    typedef struct packed {
        logic                   active;
        logic                   in_bank;
        logic                   load;
        logic [SLOT_W-1:0]      done_slot;
        logic [NEXT_W-1:0]      next_slot;
        logic                   high_current;
        logic [MUX_W-1:0]       mux_code;
        logic                   calibrate;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   level;
    } ssdf_cmd_t;

    // Analog input number for each slot position within a bank.
    function automatic logic [MUX_W-1:0] mux_code_of(input logic [2:0] pos);
        logic [MUX_W-1:0] code;
        case (pos)
            3'd0: code = 4'h6;
            3'd1: code = 4'h7;
            3'd2: code = 4'h8;
            3'd3: code = 4'h9;
            3'd4: code = 4'hA;
            3'd5: code = 4'hB;
            3'd6: code = 4'h2;
            3'd7: code = 4'h4;
            default: code = 4'h6;
        endcase
        return code;
    endfunction

endpackage

// ===== hw/rtl/sensor_scan_debounce_filter.sv =====
// Top level of the sensor scan debounce filter: configuration, front, queue and back.
//
//   Channel  Ports                          Carries
//   -------  -----------------------------  ----------------------------------------
//   input    s_valid, s_ready, s_data       one conversion: sample and switch level
//   result   m_valid, m_ready, m_data       one result per conversion
//   config   cfg_we, cfg_index, cfg_wdata   register writes, no wait, no read-back
//
// One transaction per cycle is sustained while m_ready is high. A conversion is stored in
// the queue, then its result is held in the back's output register until m_ready takes it.
// The four-entry queue lets the input keep flowing while the result side is stalled.
// Reset (aresetn, synchronous) reloads the startup counter with 100, the scan slot with 32
// and clears switch state, debounce counters and both filter banks in the same cycle.
// The startup counter reloads with a constant on every reset and startup delay writes
// are ignored, so a written delay has no visible effect.
module sensor_scan_debounce_filter
    import ssdf_pkg::*;
#(
    parameter int SWITCH_COUNT = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ssdf_in_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ssdf_out_t              m_data
);

    logic [DEB_W-1:0]   debounce_count_reg;
    logic [SHIFT_W-1:0] filter_shift_reg;
    logic               q_full;
    logic               q_push;
    ssdf_cmd_t          q_cmd;
    logic               q_pop;
    logic               q_head_valid;
    ssdf_cmd_t          q_head_cmd;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_count_reg <= DEBOUNCE_RESET;
            filter_shift_reg   <= SHIFT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DEBOUNCE_COUNT: debounce_count_reg <= cfg_wdata[DEB_W-1:0];
                REG_FILTER_SHIFT:   filter_shift_reg   <= cfg_wdata[SHIFT_W-1:0];
                default: begin
                    // Startup delay and unused indexes leave the registers unchanged.
                end
            endcase
        end
    end

    ssdf_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    ssdf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    ssdf_back #(
        .SWITCH_COUNT (SWITCH_COUNT)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .debounce_count (debounce_count_reg),
        .filter_shift   (filter_shift_reg),
        .head_valid     (q_head_valid),
        .head_cmd       (q_head_cmd),
        .pop            (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );

endmodule

// ===== hw/rtl/ssdf_front.sv =====
// Front part: accepts conversions, runs the startup counter and scan slot, classifies work.
module ssdf_front
    import ssdf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ssdf_in_t  s_data,
    input  logic      q_full,
    output logic      q_push,
    output ssdf_cmd_t q_cmd
);

    logic [COUNT_W-1:0] startup_count_reg, startup_count_next;
    logic [SLOT_W-1:0]  scan_slot_reg, scan_slot_next;
    logic [SLOT_W-1:0]  slot_inc;
    logic [SLOT_W-1:0]  next_slot;
    logic               active;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Startup countdown stops at zero; scanning starts below the threshold.
    always_comb begin
        if (startup_count_reg != '0) begin
            startup_count_next = startup_count_reg - 1'b1;
        end else begin
            startup_count_next = startup_count_reg;
        end
        active = startup_count_next < SCAN_THRESHOLD;
    end

    // Slot advances through the banks and the calibration slot, then wraps.
    always_comb begin
        slot_inc = scan_slot_reg + 1'b1;
        if (slot_inc > LAST_SLOT) begin
            next_slot = '0;
        end else begin
            next_slot = slot_inc;
        end
        scan_slot_next = active ? next_slot : scan_slot_reg;
    end

    // Classification of the accepted transaction.
    always_comb begin
        q_cmd              = '0;
        q_cmd.sample       = s_data.adc_sample;
        q_cmd.level        = s_data.switch_level;
        q_cmd.active       = active;
        if (active) begin
            q_cmd.in_bank      = scan_slot_reg < BANK_SLOTS;
            q_cmd.load         = startup_count_next != '0;
            q_cmd.done_slot    = scan_slot_reg;
            q_cmd.next_slot    = next_slot[NEXT_W-1:0];
            q_cmd.high_current = next_slot >= HIGH_BANK_SLOT;
            q_cmd.mux_code     = mux_code_of(next_slot[2:0]);
            q_cmd.calibrate    = next_slot == LAST_SLOT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            startup_count_reg <= STARTUP_RESET;
            scan_slot_reg     <= SCAN_START;
        end else if (q_push) begin
            startup_count_reg <= startup_count_next;
            scan_slot_reg     <= scan_slot_next;
        end
    end

endmodule

// ===== hw/rtl/ssdf_queue.sv =====
// Short queue of classified work between the front and back parts.
module ssdf_queue
    import ssdf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  ssdf_cmd_t push_cmd,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output ssdf_cmd_t head_cmd
);

    ssdf_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;

    assign full       = fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign head_valid = fill_reg != '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/ssdf_back.sv =====
// Back part: switch debounce, exponential filter banks and the result register.
module ssdf_back
    import ssdf_pkg::*;
#(
    parameter int SWITCH_COUNT = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [DEB_W-1:0]   debounce_count,
    input  logic [SHIFT_W-1:0] filter_shift,
    input  logic               head_valid,
    input  ssdf_cmd_t          head_cmd,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output ssdf_out_t          m_data
);

    localparam int SW_IDX_W = (SWITCH_COUNT > 1) ? $clog2(SWITCH_COUNT) : 1;
    localparam logic [3:0] SW_LIMIT = 4'(SWITCH_COUNT);

    logic [SWITCH_COUNT-1:0] switch_bits_reg, switch_bits_next;
    logic [DEB_W-1:0]        deb_cnt_reg [SWITCH_COUNT];
    logic [DEB_W-1:0]        deb_cnt_next;
    logic [SAMPLE_BITS-1:0]  store_reg [16];
    logic                    out_valid_reg;
    ssdf_out_t               out_data_reg, out_data_next;

    logic                    do_bank;
    logic                    do_debounce;
    logic [SW_IDX_W-1:0]     sw_idx;
    logic [3:0]              store_idx;
    logic [DEB_W-1:0]        cnt_inc;
    logic [SAMPLE_BITS-1:0]  old_value;
    logic [ACC_W-1:0]        acc;
    logic [ACC_W-1:0]        acc_shifted;
    logic [SAMPLE_BITS-1:0]  new_value;
    logic [SWITCH_W-1:0]     states_wide;

    assign pop     = head_valid && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign do_bank     = head_cmd.active && head_cmd.in_bank;
    assign do_debounce = do_bank && ({1'b0, head_cmd.done_slot[2:0]} < SW_LIMIT);
    assign sw_idx      = head_cmd.done_slot[SW_IDX_W-1:0];
    assign store_idx   = head_cmd.done_slot[3:0];

    // Debounce: a poll matching the stored bit counts toward a toggle.
    always_comb begin
        switch_bits_next = switch_bits_reg;
        cnt_inc          = deb_cnt_reg[sw_idx] + 1'b1;
        deb_cnt_next     = '0;
        if (switch_bits_reg[sw_idx] == head_cmd.level) begin
            if (cnt_inc >= debounce_count) begin
                switch_bits_next[sw_idx] = !head_cmd.level;
            end else begin
                deb_cnt_next = cnt_inc;
            end
        end
        if (!do_debounce) begin
            switch_bits_next = switch_bits_reg;
        end
    end

    // Filter step: old*(2^k-1)+sample is formed as (old<<k)-old+sample.
    always_comb begin
        old_value   = store_reg[store_idx];
        acc         = (ACC_W'(old_value) << filter_shift) - ACC_W'(old_value)
                      + ACC_W'(head_cmd.sample);
        acc_shifted = acc >> filter_shift;
        if (head_cmd.load) begin
            new_value = head_cmd.sample;
        end else begin
            new_value = acc_shifted[SAMPLE_BITS-1:0];
        end
    end

    // Result assembly.
    always_comb begin
        states_wide                       = '0;
        states_wide[SWITCH_COUNT-1:0]     = switch_bits_next;
        out_data_next                     = '0;
        out_data_next.switch_states       = states_wide;
        out_data_next.scan_active         = head_cmd.active;
        out_data_next.done_slot           = head_cmd.done_slot;
        out_data_next.filtered_valid      = do_bank;
        out_data_next.filtered_value      = do_bank ? new_value : '0;
        out_data_next.next_slot           = head_cmd.next_slot;
        out_data_next.high_current_select = head_cmd.high_current;
        out_data_next.mux_code            = head_cmd.mux_code;
        out_data_next.calibrate           = head_cmd.calibrate;
    end

    // Switch state and debounce counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            switch_bits_reg <= '0;
            for (int i = 0; i < SWITCH_COUNT; i++) begin
                deb_cnt_reg[i] <= '0;
            end
        end else if (pop && do_debounce) begin
            switch_bits_reg     <= switch_bits_next;
            deb_cnt_reg[sw_idx] <= deb_cnt_next;
        end
    end

    // Filter banks, cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                store_reg[i] <= '0;
            end
        end else if (pop && do_bank) begin
            store_reg[store_idx] <= new_value;
        end
    end

    // Output register: refilled from a waiting queue entry whenever it is empty or being taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
